FILE: rtl/core/pwm_pkg.sv
// Package for the pulse width measurement block: phase codes, register indexes, widths.
`timescale 1ns / 1ps

package pwm_pkg;

   // Field and register widths
   localparam int COUNT_W    = 32;
   localparam int PRESCALE_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_US  = 1'd1;

   // Register reset values
   localparam logic [COUNT_W-1:0]    TIMEOUT_RESET = 32'd360000000;
   localparam logic [PRESCALE_W-1:0] TPU_RESET     = 16'd120;
   localparam logic [COUNT_W-1:0]    COUNT_MAX     = '1;

   // Operation codes carried in req_tuser
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Measurement phases
   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_WAIT_OFF = 2'd1,
      PH_WAIT_ON  = 2'd2,
      PH_COUNT    = 2'd3
   } phase_type;

   // One result transaction
   typedef struct packed {
      logic [COUNT_W-1:0] width_us;
      logic               timed_out;
   } result_type;

endpackage

FILE: rtl/core/pulse_width_measure_top.sv
// Pulse width measurement: phase control, counters and a two-deep result buffer.
// A result is registered into the output entry (or the skid entry) and shown on rsp_tvalid.
// Throughput: one request per cycle while req_tready is high; phase logic is combinational.
// A two-entry output buffer keeps req_tready high while one result waits downstream.
// Reset (synchronous, active high) sets phase idle, clears counters and buffer,
// and loads timeout_ticks = 360000000 and ticks_per_us = 120.
`timescale 1ns / 1ps

module pulse_width_measure_top (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pwm_pkg::REQ_DATA_W-1:0]      req_tdata,   // [0] target_level, [1] pin_level
   input  logic                                req_tuser,   // [0] operation
   // Result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pwm_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // [31:0] width_us
   output logic                                rsp_tuser,   // [0] timed_out
   // Configuration port
   input  logic                                csr_write_en,
   input  logic [pwm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pwm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import pwm_pkg::*;

   // Configuration registers
   logic [COUNT_W-1:0]    timeout_ticks_ff;
   logic [PRESCALE_W-1:0] ticks_per_us_ff;

   // Measurement state
   phase_type             phase_ff, phase_in;
   logic                  wanted_ff, wanted_in;
   logic [COUNT_W-1:0]    elapsed_ff, elapsed_in;
   logic [PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic [COUNT_W-1:0]    width_ff, width_in;

   // Result buffer
   logic                  out_valid_ff, skid_valid_ff;
   result_type            out_data_ff, skid_data_ff;

   logic                  req_accept, rsp_pop;
   logic                  req_start, req_target, req_pin;
   logic                  at_level;
   logic [COUNT_W-1:0]    elapsed_inc;
   logic                  push;
   result_type            push_data;

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = out_valid_ff && rsp_tready;
   assign req_start  = (req_tuser == OP_START);
   assign req_target = req_tdata[0];
   assign req_pin    = req_tdata[1];
   assign at_level   = (req_pin == wanted_ff);
   assign elapsed_inc = (elapsed_ff == COUNT_MAX) ? elapsed_ff : elapsed_ff + 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_RESET;
         ticks_per_us_ff  <= TPU_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            CSR_TICKS_PER_US:  ticks_per_us_ff  <= csr_wdata[PRESCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Phase register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         wanted_ff   <= 1'b0;
         elapsed_ff  <= '0;
         prescale_ff <= '0;
         width_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         wanted_ff   <= wanted_in;
         elapsed_ff  <= elapsed_in;
         prescale_ff <= prescale_in;
         width_ff    <= width_in;
      end
   end

   // Next state and result for one request transaction
   always_comb begin
      logic [PRESCALE_W:0]   pre_base;
      logic [COUNT_W-1:0]    wid_base;
      logic [PRESCALE_W:0]   pre_next;
      logic                  do_count;

      phase_in    = phase_ff;
      wanted_in   = wanted_ff;
      elapsed_in  = elapsed_ff;
      prescale_in = prescale_ff;
      width_in    = width_ff;
      push        = 1'b0;
      push_data   = '{width_us: width_ff, timed_out: 1'b0};
      do_count    = 1'b0;
      pre_base    = {1'b0, prescale_ff};
      wid_base    = width_ff;

      if (req_accept) begin
         if (req_start) begin
            // Start or restart
            wanted_in   = req_target;
            phase_in    = PH_WAIT_OFF;
            elapsed_in  = '0;
            prescale_in = '0;
            width_in    = '0;
         end else if (phase_ff != PH_IDLE) begin
            elapsed_in = elapsed_inc;
            if (phase_ff == PH_COUNT && !at_level) begin
               // Pulse end wins over timeout
               push     = 1'b1;
               phase_in = PH_IDLE;
            end else if (elapsed_inc > timeout_ticks_ff) begin
               push      = 1'b1;
               push_data = '{width_us: '0, timed_out: 1'b1};
               phase_in  = PH_IDLE;
            end else begin
               case (phase_ff)
                  PH_WAIT_OFF: begin
                     if (!at_level) phase_in = PH_WAIT_ON;
                  end
                  PH_WAIT_ON: begin
                     if (at_level) begin
                        phase_in = PH_COUNT;
                        pre_base = '0;
                        wid_base = '0;
                        do_count = 1'b1;
                     end
                  end
                  PH_COUNT: do_count = 1'b1;
                  default: ;
               endcase
            end
         end
      end

      // Prescaler: one microsecond every ticks_per_us ticks
      pre_next = pre_base + 1'b1;
      if (do_count) begin
         if (pre_next >= {1'b0, ticks_per_us_ff}) begin
            prescale_in = '0;
            width_in    = (wid_base == COUNT_MAX) ? wid_base : wid_base + 1'b1;
         end else begin
            prescale_in = pre_next[PRESCALE_W-1:0];
            width_in    = wid_base;
         end
      end
   end

   // Two-entry result buffer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || rsp_pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Buffer payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) out_data_ff <= skid_data_ff;
      end else if (push) begin
         if (!out_valid_ff || rsp_pop) out_data_ff <= push_data;
         else skid_data_ff <= push_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff.width_us;
   assign rsp_tuser  = out_data_ff.timed_out;

`ifndef NO_ASSERTIONS
   // Skid entry is only ever occupied behind a full output entry
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with output entry empty");

   // A timeout result always carries zero width
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("timeout result with non-zero width");

   // A start transaction always arms the first wait phase
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_start) |=> (phase_ff == PH_WAIT_OFF))
      else $error("start did not enter wait phase");

   // Producing a result always returns to idle
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      push |=> (phase_ff == PH_IDLE && rsp_tvalid))
      else $error("result produced without going idle");

   // Width counter stays unchanged while idle and no request is accepted
   a_idle_no_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE && !req_accept) |=> $stable(width_ff))
      else $error("width counter moved while idle");
`endif

endmodule

FILE: tb/tb_pulse_width_measure_top.sv
// Self-checking testbench for the pulse width measurement block.
`timescale 1ns / 1ps

module tb_pulse_width_measure_top;
   import pwm_pkg::*;

   localparam int IDLE_PCT        = 21;
   localparam int HOLD_CYCLES     = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int N_PHASES        = 6;
   localparam int ITEMS_PER_PHASE = 70;

   typedef enum logic [1:0] {ROW_ITEM, ROW_RESULT, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic                   op;
      logic                   tgt;
      logic                   pin;
      logic [CSR_IDX_W-1:0]   idx;
      logic [COUNT_W-1:0]     val;
      logic                   tmo;
   } stim_row_type;

   logic                    clock        = 1'b0;
   logic                    reset        = 1'b1;
   logic                    req_tvalid   = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata    = '0;    // [0] target_level, [1] pin_level
   logic                    req_tuser    = 1'b0;  // [0] operation
   logic                    rsp_tvalid;
   logic                    rsp_tready   = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;            // [31:0] width_us
   logic                    rsp_tuser;            // [0] timed_out
   logic                    csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index    = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata    = '0;

   // Predictor state and its copy of the registers
   phase_type               p_phase    = PH_IDLE;
   logic                    p_level    = 1'b0;
   logic [COUNT_W-1:0]      p_elapsed  = '0;
   logic [PRESCALE_W-1:0]   p_prescale = '0;
   logic [COUNT_W-1:0]      p_width    = '0;
   logic [COUNT_W-1:0]      p_timeout  = TIMEOUT_RESET;
   logic [PRESCALE_W-1:0]   p_tpu      = TPU_RESET;

   result_type              expected_widths [$];
   stim_row_type            stim_table [$];
   int                      errors     = 0;
   int                      items_sent = 0;
   bit                      tx_gaps    = 1'b1;
   bit                      rx_gaps    = 1'b1;
   bit                      hold_req   = 1'b0;
   int                      quiet_cycles = 0;

   pulse_width_measure_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #2 clock = ~clock;

   // One pulse tick through the microsecond prescaler, width saturating
   function automatic void advance_prescaler();
      logic [PRESCALE_W:0] nxt;
      nxt = p_prescale + 1'b1;
      if (nxt >= {1'b0, p_tpu}) begin
         p_prescale = '0;
         if (p_width != COUNT_MAX)
            p_width = p_width + 1'b1;
      end else begin
         p_prescale = nxt[PRESCALE_W-1:0];
      end
   endfunction

   // Expected outcome of one accepted request transaction
   function automatic void predict_measurement(input logic op, input logic tgt,
                                               input logic pin, output logic got,
                                               output result_type r);
      logic at_lvl;
      got = 1'b0;
      r   = '0;
      if (op == OP_START) begin
         p_level    = tgt;
         p_phase    = PH_WAIT_OFF;
         p_elapsed  = '0;
         p_prescale = '0;
         p_width    = '0;
      end else if (p_phase != PH_IDLE) begin
         if (p_elapsed != COUNT_MAX)
            p_elapsed = p_elapsed + 1'b1;
         at_lvl = (pin == p_level);
         // pulse end takes priority over timeout
         if (p_phase == PH_COUNT && !at_lvl) begin
            got        = 1'b1;
            r.width_us = p_width;
            p_phase    = PH_IDLE;
         end else if (p_elapsed > p_timeout) begin
            got         = 1'b1;
            r.timed_out = 1'b1;
            p_phase     = PH_IDLE;
         end else begin
            case (p_phase)
               PH_WAIT_OFF: begin
                  if (!at_lvl)
                     p_phase = PH_WAIT_ON;
               end
               PH_WAIT_ON: begin
                  if (at_lvl) begin
                     p_phase    = PH_COUNT;
                     p_prescale = '0;
                     p_width    = '0;
                     advance_prescaler();
                  end
               end
               default: begin
                  advance_prescaler();
               end
            endcase
         end
      end
   endfunction

   // Offer one request transaction; called and returns at a falling edge
   task automatic send_item(input logic op, input logic tgt, input logic pin,
                            input logic use_typed, input result_type typed);
      logic       got;
      result_type r;
      while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-2){1'b0}}, pin, tgt};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_measurement(op, tgt, pin, got, r);
      if (use_typed)
         expected_widths.push_back(typed);
      else if (got)
         expected_widths.push_back(r);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop offering and let every outstanding result drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_widths.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
      if (idx == CSR_TIMEOUT_TICKS)
         p_timeout = val;
      else
         p_tpu = val[PRESCALE_W-1:0];
   endtask

   task automatic add_row(input row_kind_type kind, input logic op, input logic tgt,
                          input logic pin, input logic [COUNT_W-1:0] val, input logic tmo);
      stim_row_type row;
      row.kind = kind;
      row.op   = op;
      row.tgt  = tgt;
      row.pin  = pin;
      row.idx  = '0;
      row.val  = val;
      row.tmo  = tmo;
      stim_table.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
      stim_row_type row;
      row.kind = ROW_CSR;
      row.op   = 1'b0;
      row.tgt  = 1'b0;
      row.pin  = 1'b0;
      row.idx  = idx;
      row.val  = val;
      row.tmo  = 1'b0;
      stim_table.push_back(row);
   endtask

   // One measurement: optional pre-level, gap, pulse, pulse end; some broken or noise
   task automatic measure_run();
      logic lvl;
      int   shape;
      int   n_pre;
      int   n_gap;
      int   n_pulse;
      lvl   = 1'($urandom_range(1));
      shape = $urandom_range(99);
      if (shape < 8) begin
         repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                      1'($urandom_range(1)), 1'b0, '0);
         return;
      end
      send_item(OP_START, lvl, 1'($urandom_range(1)), 1'b0, '0);
      n_pre = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
      n_gap = $urandom_range(0, 3);
      if (p_tpu >= 100 && p_tpu < 1000 && $urandom_range(3) == 0)
         n_pulse = $urandom_range(100, 260);
      else
         n_pulse = $urandom_range(1, 12);
      repeat (n_pre)   send_item(OP_TICK, 1'($urandom_range(1)), lvl, 1'b0, '0);
      repeat (n_gap)   send_item(OP_TICK, 1'($urandom_range(1)), !lvl, 1'b0, '0);
      repeat (n_pulse) send_item(OP_TICK, 1'($urandom_range(1)), lvl, 1'b0, '0);
      // broken sequence: left running, the next start restarts it
      if (shape < 16)
         return;
      send_item(OP_TICK, 1'($urandom_range(1)), !lvl, 1'b0, '0);
   endtask

   // Stimulus: reset, directed table, then randomised phases
   initial begin : stimulus
      stim_row_type row;
      result_type   typed;
      int           ph;
      int           first_item;
      bit           paused;

      // reset values: tick while idle, simple pulses, restart while busy
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_START, 1'b1, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b1, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b1, '0, 1'b0);
      add_row(ROW_RESULT, OP_TICK,  1'b1, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_START, 1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b1, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_START, 1'b1, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b1, '0, 1'b0);
      add_row(ROW_RESULT, OP_TICK,  1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b1, 1'b1, '0, 1'b0);
      // zero timeout and zero prescaler: first tick times out
      add_csr(CSR_TIMEOUT_TICKS, '0);
      add_csr(CSR_TICKS_PER_US, '0);
      add_row(ROW_ITEM,   OP_START, 1'b1, 1'b0, '0, 1'b0);
      add_row(ROW_RESULT, OP_TICK,  1'b0, 1'b1, '0, 1'b1);
      // pulse end on the same tick as the timeout
      add_csr(CSR_TIMEOUT_TICKS, 32'd3);
      add_row(ROW_ITEM,   OP_START, 1'b1, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b1, 1'b1, '0, 1'b0);
      add_row(ROW_RESULT, OP_TICK,  1'b0, 1'b0, 32'd2, 1'b0);
      // largest registers: short low pulse rounds down to zero
      add_csr(CSR_TIMEOUT_TICKS, COUNT_MAX);
      add_csr(CSR_TICKS_PER_US, 32'hFFFF);
      add_row(ROW_ITEM,   OP_START, 1'b0, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b1, 1'b1, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b1, 1'b0, '0, 1'b0);
      add_row(ROW_ITEM,   OP_TICK,  1'b0, 1'b0, '0, 1'b0);
      add_row(ROW_RESULT, OP_TICK,  1'b1, 1'b1, '0, 1'b0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.kind == ROW_CSR) begin
            settle();
            csr_write(row.idx, row.val);
         end else begin
            typed.width_us  = row.val;
            typed.timed_out = row.tmo;
            send_item(row.op, row.tgt, row.pin, row.kind == ROW_RESULT, typed);
         end
      end

      for (ph = 0; ph < N_PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               csr_write(CSR_TIMEOUT_TICKS, COUNT_MAX);
               csr_write(CSR_TICKS_PER_US, 32'd1);
            end
            1: begin
               csr_write(CSR_TIMEOUT_TICKS, 32'd30);
               csr_write(CSR_TICKS_PER_US, 32'd3);
            end
            2: begin
               csr_write(CSR_TIMEOUT_TICKS, 32'd1);
               csr_write(CSR_TICKS_PER_US, 32'd2);
            end
            3: begin
               csr_write(CSR_TIMEOUT_TICKS, 32'd25);
               csr_write(CSR_TICKS_PER_US, 32'hFFFF);
            end
            4: begin
               csr_write(CSR_TIMEOUT_TICKS, TIMEOUT_RESET);
               csr_write(CSR_TICKS_PER_US, {16'd0, TPU_RESET});
            end
            default: begin
               csr_write(CSR_TIMEOUT_TICKS, $urandom_range(5, 60));
               csr_write(CSR_TICKS_PER_US, $urandom_range(1, 6));
            end
         endcase
         // phase 2 runs without any idling on either side
         tx_gaps = (ph != 2);
         rx_gaps = (ph != 2);
         if (ph == 1)
            hold_req = 1'b1;
         first_item = items_sent;
         paused     = 1'b0;
         while (items_sent - first_item < ITEMS_PER_PHASE) begin
            measure_run();
            // sender pauses until every result is back
            if (ph == N_PHASES - 1 && !paused &&
                items_sent - first_item > ITEMS_PER_PHASE / 2) begin
               settle();
               paused = 1'b1;
            end
         end
      end

      settle();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_widths.size() == 0)
         $display("PASS pulse_width_measure_top");
      else
         $display("FAIL pulse_width_measure_top");
      $finish;
   end

   // Result receiver: random back-pressure plus one long hold-off
   initial begin : rsp_drive
      int held;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= !(rx_gaps && $urandom_range(99) < IDLE_PCT);
      end
   end

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_widths.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual width_us %0d timed_out %0b",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = expected_widths.pop_front();
            if (rsp_tdata !== want.width_us) begin
               $display("%0t: width_us mismatch: expected %0d, actual %0d",
                        $time, want.width_us, rsp_tdata);
               errors++;
            end
            if (rsp_tuser !== want.timed_out) begin
               $display("%0t: timed_out mismatch: expected %0b, actual %0b",
                        $time, want.timed_out, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog: no transaction for %0d cycles", $time, quiet_cycles);
         $display("FAIL pulse_width_measure_top");
         $finish;
      end
   end

endmodule

FILE: pulse_width_measure_top.f
rtl/core/pwm_pkg.sv
rtl/core/pulse_width_measure_top.sv
tb/tb_pulse_width_measure_top.sv
